// ===== hw/rtl/mmp_pkg.sv =====
// ----------------------------------------------------------------------------
// Meter poll master package
// Shared types, codes, the register address table and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package mmp_pkg;

   localparam int unsigned NUM_REGISTERS = 14;
   localparam logic [7:0] FUNC_READ_INPUT = 8'd4;
   localparam logic [7:0] QUERY_QTY_HI = 8'd0;
   localparam logic [7:0] QUERY_QTY_LO = 8'd2;
   localparam logic [15:0] CRC_INIT = 16'hffff;
   localparam logic [15:0] CRC_POLY = 16'ha001;
   localparam logic [7:0] NODE_ADDR_RESET = 8'd1;

   // Input command codes.
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_BYTE  = 1'b1;

   // Beat positions of one result burst in the emitter.
   localparam logic [3:0] STEP_HEAD    = 4'd0;
   localparam logic [3:0] STEP_SLAVE   = 4'd1;
   localparam logic [3:0] STEP_FUNC    = 4'd2;
   localparam logic [3:0] STEP_ADDR_HI = 4'd3;
   localparam logic [3:0] STEP_ADDR_LO = 4'd4;
   localparam logic [3:0] STEP_QTY_HI  = 4'd5;
   localparam logic [3:0] STEP_QTY_LO  = 4'd6;
   localparam logic [3:0] STEP_CRC_LO  = 4'd7;
   localparam logic [3:0] STEP_CRC_HI  = 4'd8;

   typedef enum logic [2:0] {
      KIND_TX       = 3'd0,
      KIND_ACCEPTED = 3'd1,
      KIND_REJECTED = 3'd2,
      KIND_FINISHED = 3'd3,
      KIND_REFUSED  = 3'd4
   } result_kind_type;

   typedef enum logic {
      PHASE_HEADER = 1'b0,
      PHASE_BODY   = 1'b1
   } phase_type;

   typedef enum logic [1:0] {
      HEAD_NONE     = 2'd0,
      HEAD_ACCEPTED = 2'd1,
      HEAD_REJECTED = 2'd2,
      HEAD_REFUSED  = 2'd3
   } head_type;

   typedef enum logic [1:0] {
      TAIL_NONE   = 2'd0,
      TAIL_QUERY  = 2'd1,
      TAIL_FINISH = 2'd2
   } tail_type;

   // Everything the emitter needs to stream the results of one transaction.
   typedef struct packed {
      head_type    head;
      tail_type    tail;
      logic [3:0]  head_index;
      logic [31:0] head_value;
      logic [3:0]  query_index;
   } burst_type;

   // Start address of each polled register; unused slots read as zero.
   function automatic logic [15:0] reg_addr(input logic [3:0] idx);
      logic [15:0] a;
      case (idx)
         4'd0:    a = 16'h0000;
         4'd1:    a = 16'h0006;
         4'd2:    a = 16'h000c;
         4'd3:    a = 16'h0012;
         4'd4:    a = 16'h0018;
         4'd5:    a = 16'h001e;
         4'd6:    a = 16'h0024;
         4'd7:    a = 16'h0046;
         4'd8:    a = 16'h0048;
         4'd9:    a = 16'h004a;
         4'd10:   a = 16'h004c;
         4'd11:   a = 16'h004e;
         4'd12:   a = 16'h0156;
         4'd13:   a = 16'h0158;
         default: a = 16'h0000;
      endcase
      return a;
   endfunction

   // One byte of the reflected Modbus CRC-16.
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int j = 0; j < 8; j++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/mmp_if.sv =====
// ----------------------------------------------------------------------------
// Meter poll master channels
// Valid/ready channels for requests, responses and the address register.
// ----------------------------------------------------------------------------
interface mmp_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface mmp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  result_kind;
   logic [7:0]  tx_byte;
   logic [3:0]  register_index;
   logic [31:0] value_bits;
   logic        last;

   modport source (output valid, output result_kind, output tx_byte,
                   output register_index, output value_bits, output last,
                   input ready);
   modport sink (input valid, input result_kind, input tx_byte,
                 input register_index, input value_bits, input last,
                 output ready);
endinterface

interface mmp_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] node_addr;

   modport source (output valid, output node_addr, input ready);
   modport sink (input valid, input node_addr, output ready);
endinterface

// ===== hw/rtl/mmp_frame.sv =====
// ----------------------------------------------------------------------------
// Meter poll frame tracker
// Holds the poll state, parses response frames and plans each result burst.
// ----------------------------------------------------------------------------
module mmp_frame #(
   parameter int unsigned NUM_REGS = mmp_pkg::NUM_REGISTERS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic               cmd,
   input  logic [7:0]         rx_byte,
   output logic               burst_valid,
   output mmp_pkg::burst_type burst
);
   import mmp_pkg::*;

   logic        busy_ff, busy_in;
   phase_type   phase_ff, phase_in;
   logic [3:0]  reg_index_ff, reg_index_in;
   logic [8:0]  byte_count_ff, byte_count_in;
   logic [8:0]  body_length_ff, body_length_in;
   logic [15:0] crc_ff, crc_in;
   logic [31:0] value_ff, value_in;

   logic [15:0] crc_byte;
   logic [8:0]  count_inc;
   logic [9:0]  count_plus2;
   logic [4:0]  index_inc;
   logic        good;

   assign crc_byte    = crc_step(crc_ff, rx_byte);
   assign count_inc   = byte_count_ff + 9'd1;
   assign count_plus2 = {1'b0, byte_count_ff} + 10'd2;
   assign index_inc   = {1'b0, reg_index_ff} + 5'd1;
   assign good        = (crc_ff == {rx_byte, 8'h00}) && (body_length_ff >= 9'd6);

   always_comb begin
      busy_in        = busy_ff;
      phase_in       = phase_ff;
      reg_index_in   = reg_index_ff;
      byte_count_in  = byte_count_ff;
      body_length_in = body_length_ff;
      crc_in         = crc_ff;
      value_in       = value_ff;
      burst_valid    = 1'b0;
      burst          = '{head: HEAD_NONE, tail: TAIL_NONE, head_index: 4'd0,
                         head_value: 32'd0, query_index: 4'd0};

      if (take) begin
         if (cmd == CMD_START) begin
            burst_valid = 1'b1;
            if (busy_ff) begin
               burst.head       = HEAD_REFUSED;
               burst.head_index = reg_index_ff;
            end else begin
               busy_in           = 1'b1;
               reg_index_in      = 4'd0;
               burst.tail        = TAIL_QUERY;
               burst.query_index = 4'd0;
               phase_in          = PHASE_HEADER;
               byte_count_in     = 9'd0;
               body_length_in    = 9'd0;
               crc_in            = CRC_INIT;
               value_in          = 32'd0;
            end
         end else if (busy_ff) begin
            if (phase_ff == PHASE_HEADER) begin
               crc_in        = crc_byte;
               byte_count_in = count_inc;
               if (count_inc >= 9'd3) begin
                  if (rx_byte == 8'd0) begin
                     // Empty byte count: start over on a fresh header.
                     byte_count_in  = 9'd0;
                     body_length_in = 9'd0;
                     crc_in         = CRC_INIT;
                     value_in       = 32'd0;
                  end else begin
                     body_length_in = {1'b0, rx_byte} + 9'd2;
                     byte_count_in  = 9'd0;
                     value_in       = 32'd0;
                     phase_in       = PHASE_BODY;
                  end
               end
            end else if (count_plus2 < {1'b0, body_length_ff}) begin
               crc_in = crc_byte;
               if (byte_count_ff < 9'd4) begin
                  value_in = {value_ff[23:0], rx_byte};
               end
               byte_count_in = count_inc;
            end else if (count_plus2 == {1'b0, body_length_ff}) begin
               // CRC low byte folds in; the high byte must then match.
               crc_in        = crc_ff ^ {8'h00, rx_byte};
               byte_count_in = count_inc;
            end else begin
               burst_valid      = 1'b1;
               burst.head       = good ? HEAD_ACCEPTED : HEAD_REJECTED;
               burst.head_index = reg_index_ff;
               burst.head_value = good ? value_ff : 32'd0;
               phase_in         = PHASE_HEADER;
               byte_count_in    = 9'd0;
               body_length_in   = 9'd0;
               crc_in           = CRC_INIT;
               value_in         = 32'd0;
               if (index_inc >= 5'(NUM_REGS)) begin
                  busy_in    = 1'b0;
                  burst.tail = TAIL_FINISH;
               end else begin
                  reg_index_in      = index_inc[3:0];
                  burst.tail        = TAIL_QUERY;
                  burst.query_index = index_inc[3:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         phase_ff       <= PHASE_HEADER;
         reg_index_ff   <= 4'd0;
         byte_count_ff  <= 9'd0;
         body_length_ff <= 9'd0;
         crc_ff         <= CRC_INIT;
         value_ff       <= 32'd0;
      end else begin
         busy_ff        <= busy_in;
         phase_ff       <= phase_in;
         reg_index_ff   <= reg_index_in;
         byte_count_ff  <= byte_count_in;
         body_length_ff <= body_length_in;
         crc_ff         <= crc_in;
         value_ff       <= value_in;
      end
   end

endmodule

// ===== hw/rtl/mmp_emit.sv =====
// ----------------------------------------------------------------------------
// Meter poll result emitter
// Streams one planned burst as result transactions through an output register.
// ----------------------------------------------------------------------------
module mmp_emit #(
   parameter int unsigned NUM_REGS = mmp_pkg::NUM_REGISTERS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               burst_valid,
   input  mmp_pkg::burst_type burst,
   input  logic [7:0]         node_addr,
   output logic               desc_busy,
   mmp_rsp_if.source          rsp
);
   import mmp_pkg::*;

   logic        desc_valid_ff, desc_valid_in;
   burst_type   desc_ff;
   logic [3:0]  step_ff, step_in;
   logic [15:0] crc_ff, crc_in;
   logic        out_valid_ff, out_valid_in;
   result_kind_type kind_ff;
   logic [7:0]  tx_ff;
   logic [3:0]  index_ff;
   logic [31:0] value_ff;
   logic        last_ff;

   logic            advance;
   logic            beat_final;
   result_kind_type beat_kind;
   logic [7:0]      beat_tx;
   logic [3:0]      beat_index;
   logic [31:0]     beat_value;
   logic [15:0]     query_addr;

   assign query_addr = reg_addr(desc_ff.query_index);
   assign advance    = desc_valid_ff && (!out_valid_ff || rsp.ready);
   assign desc_busy  = desc_valid_ff;

   always_comb begin
      beat_kind  = KIND_TX;
      beat_tx    = 8'd0;
      beat_index = desc_ff.query_index;
      beat_value = 32'd0;
      beat_final = 1'b0;
      if (step_ff == STEP_HEAD) begin
         case (desc_ff.head)
            HEAD_ACCEPTED: beat_kind = KIND_ACCEPTED;
            HEAD_REJECTED: beat_kind = KIND_REJECTED;
            default:       beat_kind = KIND_REFUSED;
         endcase
         beat_index = desc_ff.head_index;
         beat_value = desc_ff.head_value;
         beat_final = (desc_ff.tail == TAIL_NONE);
      end else if (desc_ff.tail == TAIL_FINISH) begin
         beat_kind  = KIND_FINISHED;
         beat_index = 4'(NUM_REGS - 1);
         beat_final = 1'b1;
      end else begin
         case (step_ff)
            STEP_SLAVE:   beat_tx = node_addr;
            STEP_FUNC:    beat_tx = FUNC_READ_INPUT;
            STEP_ADDR_HI: beat_tx = query_addr[15:8];
            STEP_ADDR_LO: beat_tx = query_addr[7:0];
            STEP_QTY_HI:  beat_tx = QUERY_QTY_HI;
            STEP_QTY_LO:  beat_tx = QUERY_QTY_LO;
            STEP_CRC_LO:  beat_tx = crc_ff[7:0];
            STEP_CRC_HI:  beat_tx = crc_ff[15:8];
            default:      beat_tx = 8'd0;
         endcase
         beat_final = (step_ff == STEP_CRC_HI);
      end
   end

   always_comb begin
      desc_valid_in = desc_valid_ff;
      step_in       = step_ff;
      crc_in        = crc_ff;
      if (burst_valid && !desc_valid_ff) begin
         desc_valid_in = 1'b1;
         step_in       = (burst.head == HEAD_NONE) ? STEP_SLAVE : STEP_HEAD;
         crc_in        = CRC_INIT;
      end else if (advance) begin
         step_in = step_ff + 4'd1;
         if (beat_final) begin
            desc_valid_in = 1'b0;
         end
         // The query CRC accumulates over the six bytes ahead of it.
         if (step_ff >= STEP_SLAVE && step_ff <= STEP_QTY_LO) begin
            crc_in = crc_step(crc_ff, beat_tx);
         end
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         step_ff       <= STEP_HEAD;
         crc_ff        <= CRC_INIT;
      end else begin
         desc_valid_ff <= desc_valid_in;
         out_valid_ff  <= out_valid_in;
         step_ff       <= step_in;
         crc_ff        <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (burst_valid && !desc_valid_ff) begin
         desc_ff <= burst;
      end
      if (advance) begin
         kind_ff  <= beat_kind;
         tx_ff    <= beat_tx;
         index_ff <= beat_index;
         value_ff <= beat_value;
         last_ff  <= beat_final;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.result_kind    = kind_ff;
   assign rsp.tx_byte        = tx_ff;
   assign rsp.register_index = index_ff;
   assign rsp.value_bits     = value_ff;
   assign rsp.last           = last_ff;

endmodule

// ===== hw/rtl/modbus_meter_poll_master_core.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU meter poll master
// Polls a fixed list of meter input registers with read-input-registers queries.
// ----------------------------------------------------------------------------
// Usage: a request transaction on req_ch carries either a start command or one
// received serial byte. Response transactions on rsp_ch carry the query bytes
// to transmit, accepted or rejected register values, the poll-finished mark and
// start-refused marks; the last flag marks the final response of a request.
// csr_ch writes the slave address and is always ready; write it only while the
// block is idle.
// Timing: the first response of a request passes through the burst descriptor
// register and then the output register, once that is free, before it reaches
// rsp_ch. Requests that cause no response are taken every cycle while no burst
// waits in the emitter.
// Throughput: the emitter sends one response per cycle while rsp_ch is ready;
// the request channel reopens in the cycle after the previous request's final
// response enters the output register. A request has at most nine responses.
// Reset clears the poll state, sets the slave address to 1 and drops rsp_ch
// valid. A stalled receiver holds the output register and, through the
// emitter, stops request intake once a burst is pending.
// ----------------------------------------------------------------------------
module modbus_meter_poll_master_core #(
   parameter int unsigned NUM_REGS = mmp_pkg::NUM_REGISTERS
) (
   input  logic       clock,
   input  logic       reset,
   mmp_req_if.sink    req_ch,
   mmp_rsp_if.source  rsp_ch,
   mmp_csr_if.sink    csr_ch
);
   import mmp_pkg::*;

   logic [7:0] slave_ff;
   logic       take;
   logic       burst_valid;
   burst_type  burst;
   logic       desc_busy;

   // The address register takes every write at once.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_ff <= NODE_ADDR_RESET;
      end else if (csr_ch.valid) begin
         slave_ff <= csr_ch.node_addr;
      end
   end

   // Requests are accepted whenever no burst waits in the emitter.
   assign req_ch.ready = !desc_busy;
   assign take         = req_ch.valid && req_ch.ready;

   mmp_frame #(
      .NUM_REGS (NUM_REGS)
   ) u_frame (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .cmd         (req_ch.cmd),
      .rx_byte     (req_ch.rx_byte),
      .burst_valid (burst_valid),
      .burst       (burst)
   );

   mmp_emit #(
      .NUM_REGS (NUM_REGS)
   ) u_emit (
      .clock       (clock),
      .reset       (reset),
      .burst_valid (burst_valid),
      .burst       (burst),
      .node_addr   (slave_ff),
      .desc_busy   (desc_busy),
      .rsp         (rsp_ch)
   );

endmodule
